/* rtl/core/pcm_pkg.sv */
package pcm_pkg;

  localparam int ChanW   = 5;
  localparam int NumChan = 3;
  localparam int ColourW = ChanW * NumChan;
  localparam int SrcW    = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 15;
  localparam int EnableW = 6;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] REG_CLIP      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PREVENT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_USE_SUB   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ENABLE    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HALVE     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SUBTRACT  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FIXED     = 3'd6;

  // main-screen source codes
  localparam logic [SrcW-1:0] SRC_BG1      = 3'd0;
  localparam logic [SrcW-1:0] SRC_BG2      = 3'd1;
  localparam logic [SrcW-1:0] SRC_BG3      = 3'd2;
  localparam logic [SrcW-1:0] SRC_BG4      = 3'd3;
  localparam logic [SrcW-1:0] SRC_OBJ_LO   = 3'd4;
  localparam logic [SrcW-1:0] SRC_OBJ_HI   = 3'd5;
  localparam logic [SrcW-1:0] SRC_BACKDROP = 3'd6;

  // enable bit positions
  localparam int EN_OBJ_HI   = 4;
  localparam int EN_BACKDROP = 5;

  typedef struct packed {
    logic               clip;
    logic               prevent;
    logic               use_sub;
    logic [EnableW-1:0] enable;
    logic               halve;
    logic               subtract;
    logic [ColourW-1:0] fixed_col;
  } cfg_t;

  // decoded pixel after the front stage
  typedef struct packed {
    logic               valid;
    logic               math;
    logic               halve;
    logic               subtract;
    logic [ColourW-1:0] a;
    logic [ColourW-1:0] b;
  } front_t;

endpackage

/* rtl/core/pixel_colour_math_blend.sv */
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ------------------------------------------
// pixel in  in         start / busy           main_source, main_colour,
//                                             sub_is_backdrop, sub_colour
// colour    out        done (1-cycle strobe)  out_colour
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Three-stage pipeline, one pixel per clock; done is start carried through the stages.
// Stage 1 decodes source enable, clip and partner select; stage 2 does the
// per-channel 6-bit add or floored subtract; stage 3 halves or saturates, or passes main.
// busy stays low: nothing downstream can hold a word, so there is no stall.
// rst (sync, active high) clears the valid chain and all config registers to 0.
module pixel_colour_math_blend (
  input  logic                         clk,
  input  logic                         rst,
  // pixel input
  input  logic                         start,
  output logic                         busy,
  input  logic [pcm_pkg::SrcW-1:0]     main_source,
  input  logic [pcm_pkg::ColourW-1:0]  main_colour,
  input  logic                         sub_is_backdrop,
  input  logic [pcm_pkg::ColourW-1:0]  sub_colour,
  // result
  output logic                         done,
  output logic [pcm_pkg::ColourW-1:0]  out_colour,
  // config write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pcm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pcm_pkg::CfgDataW-1:0] cfg_data
);
  import pcm_pkg::*;

  cfg_t   cfg;
  front_t front;
  logic   in_accept;

  // No backpressure anywhere in the pipe
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  // Register file; a write applies to words accepted after the write edge
  pcm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Stage 1: clip, source enable, partner select, halve qualify
  pcm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_accept),
    .main_source     (main_source),
    .main_colour     (main_colour),
    .sub_is_backdrop (sub_is_backdrop),
    .sub_colour      (sub_colour),
    .front           (front)
  );

  // Stages 2 and 3: channel arithmetic and output register
  pcm_mixer u_mixer (
    .clk        (clk),
    .rst        (rst),
    .front      (front),
    .out_valid  (done),
    .out_colour (out_colour)
  );

endmodule

/* rtl/core/pcm_cfg_regs.sv */
module pcm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [pcm_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [pcm_pkg::CfgDataW-1:0] wr_data,
  output pcm_pkg::cfg_t                cfg
);
  import pcm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CLIP:     cfg.clip      <= wr_data[0];
        REG_PREVENT:  cfg.prevent   <= wr_data[0];
        REG_USE_SUB:  cfg.use_sub   <= wr_data[0];
        REG_ENABLE:   cfg.enable    <= wr_data[EnableW-1:0];
        REG_HALVE:    cfg.halve     <= wr_data[0];
        REG_SUBTRACT: cfg.subtract  <= wr_data[0];
        REG_FIXED:    cfg.fixed_col <= wr_data[ColourW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

/* rtl/core/pcm_front.sv */
module pcm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  pcm_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  input  logic [pcm_pkg::SrcW-1:0]    main_source,
  input  logic [pcm_pkg::ColourW-1:0] main_colour,
  input  logic                        sub_is_backdrop,
  input  logic [pcm_pkg::ColourW-1:0] sub_colour,
  output pcm_pkg::front_t             front
);
  import pcm_pkg::*;

  logic src_en;

  always_comb begin
    unique case (main_source)
      SRC_BG1, SRC_BG2, SRC_BG3, SRC_BG4: src_en = cfg.enable[main_source[1:0]];
      SRC_OBJ_HI:                         src_en = cfg.enable[EN_OBJ_HI];
      SRC_BACKDROP:                       src_en = cfg.enable[EN_BACKDROP];
      default:                            src_en = 1'b0;  // low-palette obj, unused code
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else begin
      front.valid <= in_valid;
    end
    front.math     <= !cfg.prevent && src_en;
    front.halve    <= cfg.halve && !cfg.clip && !(cfg.use_sub && sub_is_backdrop);
    front.subtract <= cfg.subtract;
    front.a        <= cfg.clip ? '0 : main_colour;
    front.b        <= cfg.use_sub ? sub_colour : cfg.fixed_col;
  end

endmodule

/* rtl/core/pcm_mixer.sv */
module pcm_mixer (
  input  logic                        clk,
  input  logic                        rst,
  input  pcm_pkg::front_t             front,
  output logic                        out_valid,
  output logic [pcm_pkg::ColourW-1:0] out_colour
);
  import pcm_pkg::*;

  // stage 2: raw per-channel add or floored subtract
  logic [NumChan-1:0][ChanW:0] raw_next;
  logic [NumChan-1:0][ChanW:0] raw;
  logic               s2_valid;
  logic               s2_math;
  logic               s2_halve;
  logic [ColourW-1:0] s2_main;

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      logic [ChanW:0] ca;
      logic [ChanW:0] cb;
      logic [ChanW:0] diff;
      ca   = {1'b0, front.a[ch*ChanW +: ChanW]};
      cb   = {1'b0, front.b[ch*ChanW +: ChanW]};
      diff = ca - cb;
      if (front.subtract) begin
        raw_next[ch] = diff[ChanW] ? '0 : diff;  // borrow floors at zero
      end else begin
        raw_next[ch] = ca + cb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= front.valid;
    end
    raw      <= raw_next;
    s2_math  <= front.math;
    s2_halve <= front.halve;
    s2_main  <= front.a;
  end

  // stage 3: halve or saturate, then pick math or pass-through
  logic [ColourW-1:0] mixed;

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      if (s2_halve) begin
        mixed[ch*ChanW +: ChanW] = raw[ch][ChanW:1];
      end else if (raw[ch][ChanW]) begin
        mixed[ch*ChanW +: ChanW] = '1;
      end else begin
        mixed[ch*ChanW +: ChanW] = raw[ch][ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid;
    end
    out_colour <= s2_math ? mixed : s2_main;
  end

endmodule

/* rtl/core/pcm_checker.sv */
module pcm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);

  // every accepted word comes out at done after the front, stage-2 and output registers
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted word did not complete after three cycles");

  // no result without a matching earlier accept and no reset since
  a_done_has_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3) && !$past(rst, 1) && !$past(rst, 2))
    else $error("done without matching accept");

  // reset flushes the pipe
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");

  // the pipe never stalls
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");

  // config writes are always taken
  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write held off");

endmodule

bind pixel_colour_math_blend pcm_checker u_pcm_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
